/* design/avscp_pkg.sv */
// Shared constants, types and helpers of the valve and speed command parser.
package avscp_pkg;

    localparam int LINE_MAX    = 64;
    localparam int VALVE_COUNT = 9;

    localparam int LEN_W      = $clog2(LINE_MAX + 1);
    localparam int SPEED_W    = 15;
    localparam int OUT_MASK_W = 9;
    localparam int PROD_W     = SPEED_W + 4;

    localparam logic [SPEED_W-1:0] SPEED_MAX   = '1;
    localparam logic [LEN_W-1:0]   LINE_LIMIT  = LEN_W'(LINE_MAX);
    localparam logic [4:0]         VALVE_LIMIT = 5'(VALVE_COUNT);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] SPEED_LEAD = 4'd8;

    typedef enum logic [2:0] {
        TK_OTHER,
        TK_NL,
        TK_S,
        TK_R,
        TK_V,
        TK_PIPE,
        TK_Y,
        TK_N
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic       is_digit;
        logic [3:0] digit;
    } tok_t;

    typedef struct packed {
        logic push;
        tok_t tok;
    } q_wr_t;

    typedef struct packed {
        logic pop;
    } q_rd_t;

    typedef struct packed {
        logic full;
        logic empty;
        tok_t tok;
    } q_stat_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_AFTER_R,
        PH_R_DIGITS,
        PH_AFTER_V,
        PH_V_ARG
    } phase_t;

    function automatic logic [OUT_MASK_W-1:0] mask_out(input logic [VALVE_COUNT-1:0] v);
        logic [VALVE_COUNT+OUT_MASK_W-1:0] ext;
        ext = {{OUT_MASK_W{1'b0}}, v};
        return ext[OUT_MASK_W-1:0];
    endfunction

endpackage

/* design/avscp_if.sv */
// Handshake channels for received bytes and parser results.
interface avscp_cmd_if
    import avscp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface avscp_res_if
    import avscp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [OUT_MASK_W-1:0] valve_open_mask;
    logic [SPEED_W-1:0]    speed_setpoint;
    logic                  line_committed;
    logic                  line_dropped;

    modport source (output valid, output valve_open_mask, output speed_setpoint,
                    output line_committed, output line_dropped, input ready);
    modport sink (input valid, input valve_open_mask, input speed_setpoint,
                  input line_committed, input line_dropped, output ready);
endinterface

/* design/ascii_valve_speed_command_parser.sv */
// Top level of the ASCII valve and speed command parser.
//
//  channel  direction  payload                                             transaction
//  cmd      in         rx_byte[7:0]                                        one byte
//  res      out        valve_open_mask[8:0] speed_setpoint[14:0]
//                      line_committed line_dropped                         one result
//
//  One byte per clock sustained while res takes results; each byte passes the queue and the result register.
//  Front end classifies the byte; a four-entry token queue feeds the parser.
//  The parser loop retires one token per cycle into the result register unless a held result stalls it.
//  Reset clears all parser state; no clearing pass is needed.
//  A stalled res holds its result and the queue absorbs up to four bytes.
module ascii_valve_speed_command_parser
    import avscp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    avscp_cmd_if.sink   cmd,
    avscp_res_if.source res
);

    q_wr_t   q_wr;
    q_rd_t   q_rd;
    q_stat_t q_stat;

    avscp_front u_front (
        .cmd    (cmd),
        .q_stat (q_stat),
        .q_wr   (q_wr)
    );

    avscp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_rd   (q_rd),
        .q_stat (q_stat)
    );

    avscp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_rd   (q_rd),
        .res    (res)
    );

endmodule

/* design/avscp_front.sv */
// Front end: accept received bytes and classify them into tokens.
module avscp_front
    import avscp_pkg::*;
(
    avscp_cmd_if.sink cmd,
    input  q_stat_t   q_stat,
    output q_wr_t     q_wr
);

    tok_t tok;

    always_comb
    begin
        tok.is_digit = (cmd.rx_byte >= CH_ZERO) && (cmd.rx_byte <= CH_NINE);
        tok.digit    = 4'(cmd.rx_byte - CH_ZERO);
        case (cmd.rx_byte)
            CH_NL:   tok.kind = TK_NL;
            CH_S:    tok.kind = TK_S;
            CH_R:    tok.kind = TK_R;
            CH_V:    tok.kind = TK_V;
            CH_PIPE: tok.kind = TK_PIPE;
            CH_Y:    tok.kind = TK_Y;
            CH_N:    tok.kind = TK_N;
            default: tok.kind = TK_OTHER;
        endcase
    end

    assign cmd.ready = !q_stat.full;
    assign q_wr.push = cmd.valid && !q_stat.full;
    assign q_wr.tok  = tok;

endmodule

/* design/avscp_queue.sv */
// Short token queue between the front end and the parser.
module avscp_queue
    import avscp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_wr_t   q_wr,
    input  q_rd_t   q_rd,
    output q_stat_t q_stat
);

    tok_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = q_wr.push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_rd.pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push && !q_rd.pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (!q_wr.push && q_rd.pop)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            slot_reg[wr_ptr_reg] <= q_wr.tok;
        end
    end

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.tok   = slot_reg[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.push && q_stat.full))
        else $error("push into a full token queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_rd.pop && q_stat.empty))
        else $error("pop from an empty token queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("queue pointers disagree with fill count");

endmodule

/* design/avscp_back.sv */
// Back end: parse tokens, keep pending and committed state, register results.
module avscp_back
    import avscp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    output q_rd_t      q_rd,
    avscp_res_if.source res
);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_t                 fresh_phase;
    logic [3:0]             vnum_reg;
    logic [3:0]             vnum_next;
    logic [SPEED_W-1:0]     acc_reg;
    logic [SPEED_W-1:0]     acc_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic                   stopped_reg;
    logic                   stopped_next;
    logic [VALVE_COUNT-1:0] pend_valves_reg;
    logic [VALVE_COUNT-1:0] pend_valves_next;
    logic [SPEED_W-1:0]     pend_speed_reg;
    logic [SPEED_W-1:0]     pend_speed_next;
    logic [VALVE_COUNT-1:0] act_valves_reg;
    logic [VALVE_COUNT-1:0] act_valves_next;
    logic [SPEED_W-1:0]     act_speed_reg;
    logic [SPEED_W-1:0]     act_speed_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   committed;
    logic                   dropped;

    logic                   out_valid_reg;
    logic [OUT_MASK_W-1:0]  out_mask_reg;
    logic [SPEED_W-1:0]     out_speed_reg;
    logic                   out_commit_reg;
    logic                   out_drop_reg;

    tok_t                   tok;
    logic                   pop;
    logic                   is_nl;
    logic                   at_limit;
    logic                   parse;
    logic                   is_lead;
    logic                   valve_ok;
    logic [PROD_W-1:0]      prod;

    assign tok      = q_stat.tok;
    assign pop      = !q_stat.empty && (!out_valid_reg || res.ready);
    assign q_rd.pop = pop;
    assign is_nl    = (tok.kind == TK_NL);
    assign at_limit = (len_reg >= LINE_LIMIT);
    assign parse    = !is_nl && !ovf_reg && !at_limit;
    assign is_lead  = tok.is_digit && (tok.digit == SPEED_LEAD);
    assign valve_ok = tok.is_digit && ({1'b0, tok.digit} < VALVE_LIMIT);
    assign prod     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + {{(PROD_W-4){1'b0}}, tok.digit};

    always_comb
    begin
        case (tok.kind)
            TK_R:    fresh_phase = PH_AFTER_R;
            TK_V:    fresh_phase = PH_AFTER_V;
            default: fresh_phase = PH_IDLE;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_nl || (!ovf_reg && at_limit))
        begin
            phase_next = PH_IDLE;
        end
        else if (parse)
        begin
            case (phase_reg)
                PH_AFTER_R:  phase_next = is_lead ? PH_R_DIGITS : fresh_phase;
                PH_R_DIGITS: phase_next = (tok.kind == TK_PIPE) ? PH_IDLE : PH_R_DIGITS;
                PH_AFTER_V:  phase_next = valve_ok ? PH_V_ARG : fresh_phase;
                PH_V_ARG:    phase_next = PH_IDLE;
                default:     phase_next = fresh_phase;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        vnum_next        = vnum_reg;
        acc_next         = acc_reg;
        seen_next        = seen_reg;
        stopped_next     = stopped_reg;
        pend_valves_next = pend_valves_reg;
        pend_speed_next  = pend_speed_reg;
        act_valves_next  = act_valves_reg;
        act_speed_next   = act_speed_reg;
        len_next         = len_reg;
        ovf_next         = ovf_reg;
        committed        = 1'b0;
        dropped          = 1'b0;
        if (is_nl)
        begin
            if (ovf_reg)
            begin
                pend_valves_next = act_valves_reg;
                pend_speed_next  = act_speed_reg;
                dropped          = 1'b1;
            end
            else
            begin
                act_valves_next = pend_valves_reg;
                act_speed_next  = pend_speed_reg;
                committed       = 1'b1;
            end
            acc_next     = '0;
            seen_next    = 1'b0;
            stopped_next = 1'b0;
            len_next     = '0;
            ovf_next     = 1'b0;
        end
        else if (!ovf_reg && at_limit)
        begin
            ovf_next = 1'b1;
        end
        else if (parse)
        begin
            len_next = LEN_W'(len_reg + 1'b1);
            case (phase_reg)
                PH_AFTER_R:
                begin
                    if (is_lead)
                    begin
                        acc_next     = '0;
                        seen_next    = 1'b0;
                        stopped_next = 1'b0;
                    end
                    else if (tok.kind == TK_S)
                    begin
                        pend_valves_next = '0;
                        pend_speed_next  = '0;
                    end
                end
                PH_R_DIGITS:
                begin
                    if (tok.kind == TK_PIPE)
                    begin
                        if (seen_reg)
                        begin
                            pend_speed_next = acc_reg;
                        end
                    end
                    else if (!stopped_reg && tok.is_digit)
                    begin
                        acc_next  = (prod > PROD_W'(SPEED_MAX)) ? SPEED_MAX
                                                                : prod[SPEED_W-1:0];
                        seen_next = 1'b1;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                PH_AFTER_V:
                begin
                    if (valve_ok)
                    begin
                        vnum_next = tok.digit;
                    end
                    else if (tok.kind == TK_S)
                    begin
                        pend_valves_next = '0;
                        pend_speed_next  = '0;
                    end
                end
                PH_V_ARG:
                begin
                    for (int i = 0; i < VALVE_COUNT; i++)
                    begin
                        if (vnum_reg == 4'(i))
                        begin
                            if (tok.kind == TK_Y)
                            begin
                                pend_valves_next[i] = 1'b1;
                            end
                            else if (tok.kind == TK_N)
                            begin
                                pend_valves_next[i] = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    if (tok.kind == TK_S)
                    begin
                        pend_valves_next = '0;
                        pend_speed_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            vnum_reg        <= '0;
            acc_reg         <= '0;
            seen_reg        <= 1'b0;
            stopped_reg     <= 1'b0;
            pend_valves_reg <= '0;
            pend_speed_reg  <= '0;
            act_valves_reg  <= '0;
            act_speed_reg   <= '0;
            len_reg         <= '0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                vnum_reg        <= vnum_next;
                acc_reg         <= acc_next;
                seen_reg        <= seen_next;
                stopped_reg     <= stopped_next;
                pend_valves_reg <= pend_valves_next;
                pend_speed_reg  <= pend_speed_next;
                act_valves_reg  <= act_valves_next;
                act_speed_reg   <= act_speed_next;
                len_reg         <= len_next;
                ovf_reg         <= ovf_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_mask_reg   <= mask_out(act_valves_next);
            out_speed_reg  <= act_speed_next;
            out_commit_reg <= committed;
            out_drop_reg   <= dropped;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.valve_open_mask = out_mask_reg;
    assign res.speed_setpoint  = out_speed_reg;
    assign res.line_committed  = out_commit_reg;
    assign res.line_dropped    = out_drop_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LINE_LIMIT)
        else $error("line length beyond limit");

    a_ovf_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (phase_reg == PH_IDLE))
        else $error("parsing continued on an overlong line");

    a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_nl) |=> (len_reg == '0) && !ovf_reg && out_valid_reg)
        else $error("newline did not close the line");

endmodule

/* bench/cmd_parser_checker.sv */
// Checker that predicts each parser result from accepted bytes and compares it.
module cmd_parser_checker
    import avscp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    avscp_cmd_if  cmd,
    avscp_res_if  res,
    output int    errors,
    output int    awaiting
);

    typedef struct packed {
        logic [OUT_MASK_W-1:0] mask;
        logic [SPEED_W-1:0]    speed;
        logic                  committed;
        logic                  dropped;
    } parser_result_t;

    parser_result_t         awaited_results[$];
    parser_result_t         predicted;
    parser_result_t         observed;
    int                     mismatch_tally;

    phase_t                 phase;
    logic [3:0]             valve_sel;
    logic [SPEED_W-1:0]     digit_acc;
    logic                   digits_seen;
    logic                   digits_stopped;
    logic [VALVE_COUNT-1:0] work_valves;
    logic [SPEED_W-1:0]     work_speed;
    logic [VALVE_COUNT-1:0] live_valves;
    logic [SPEED_W-1:0]     live_speed;
    int                     line_len;
    logic                   line_over;

    task start_command(input logic [7:0] c);
        phase = PH_IDLE;
        if (c == CH_S)
        begin
            work_speed  = '0;
            work_valves = '0;
        end
        else if (c == CH_R)
            phase = PH_AFTER_R;
        else if (c == CH_V)
            phase = PH_AFTER_V;
    endtask

    task parse_rx_byte(input logic [7:0] c, output parser_result_t r);
        int next_acc;
        r.committed = 1'b0;
        r.dropped   = 1'b0;
        if (c == CH_NL)
        begin
            if (line_over)
            begin
                work_valves = live_valves;
                work_speed  = live_speed;
                r.dropped   = 1'b1;
            end
            else
            begin
                live_valves = work_valves;
                live_speed  = work_speed;
                r.committed = 1'b1;
            end
            phase          = PH_IDLE;
            digit_acc      = '0;
            digits_seen    = 1'b0;
            digits_stopped = 1'b0;
            line_len       = 0;
            line_over      = 1'b0;
        end
        else if (!line_over)
        begin
            if (line_len >= LINE_MAX)
            begin
                line_over = 1'b1;
                phase     = PH_IDLE;
            end
            else
            begin
                line_len++;
                case (phase)
                    PH_AFTER_R:
                    begin
                        if (c == CH_ZERO + 8'(SPEED_LEAD))
                        begin
                            phase          = PH_R_DIGITS;
                            digit_acc      = '0;
                            digits_seen    = 1'b0;
                            digits_stopped = 1'b0;
                        end
                        else
                            start_command(c);
                    end
                    PH_R_DIGITS:
                    begin
                        if (c == CH_PIPE)
                        begin
                            if (digits_seen)
                                work_speed = digit_acc;
                            phase = PH_IDLE;
                        end
                        else if (!digits_stopped && c >= CH_ZERO && c <= CH_NINE)
                        begin
                            next_acc    = int'(digit_acc) * 10 + int'(c - CH_ZERO);
                            digit_acc   = (next_acc > int'(SPEED_MAX)) ? SPEED_MAX
                                                                       : SPEED_W'(next_acc);
                            digits_seen = 1'b1;
                        end
                        else
                            digits_stopped = 1'b1;
                    end
                    PH_AFTER_V:
                    begin
                        if (c >= CH_ZERO && int'(c - CH_ZERO) < VALVE_COUNT)
                        begin
                            valve_sel = 4'(c - CH_ZERO);
                            phase     = PH_V_ARG;
                        end
                        else
                            start_command(c);
                    end
                    PH_V_ARG:
                    begin
                        if (c == CH_Y)
                            work_valves[valve_sel] = 1'b1;
                        else if (c == CH_N)
                            work_valves[valve_sel] = 1'b0;
                        phase = PH_IDLE;
                    end
                    default:
                        start_command(c);
                endcase
            end
        end
        r.mask  = OUT_MASK_W'(live_valves);
        r.speed = live_speed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase          = PH_IDLE;
            valve_sel      = '0;
            digit_acc      = '0;
            digits_seen    = 1'b0;
            digits_stopped = 1'b0;
            work_valves    = '0;
            work_speed     = '0;
            live_valves    = '0;
            live_speed     = '0;
            line_len       = 0;
            line_over      = 1'b0;
            mismatch_tally = 0;
            awaited_results.delete();
            errors   <= 0;
            awaiting <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                parse_rx_byte(cmd.rx_byte, predicted);
                awaited_results.push_back(predicted);
            end
            if (res.valid && res.ready)
            begin
                observed.mask      = res.valve_open_mask;
                observed.speed     = res.speed_setpoint;
                observed.committed = res.line_committed;
                observed.dropped   = res.line_dropped;
                if (awaited_results.size() == 0)
                begin
                    mismatch_tally++;
                    if (mismatch_tally <= 10)
                        $display("unexpected result: mask=%h speed=%0d committed=%b dropped=%b",
                                 observed.mask, observed.speed, observed.committed,
                                 observed.dropped);
                end
                else
                begin
                    predicted = awaited_results.pop_front();
                    if (predicted.mask != observed.mask || predicted.speed != observed.speed
                        || predicted.committed != observed.committed
                        || predicted.dropped != observed.dropped)
                    begin
                        mismatch_tally++;
                        if (mismatch_tally <= 10)
                            $display({"result mismatch: expected mask=%h speed=%0d c=%b d=%b,",
                                      " got mask=%h speed=%0d c=%b d=%b"},
                                     predicted.mask, predicted.speed, predicted.committed,
                                     predicted.dropped, observed.mask, observed.speed,
                                     observed.committed, observed.dropped);
                    end
                end
            end
            errors   <= mismatch_tally;
            awaiting <= awaited_results.size();
        end
    end

endmodule

/* bench/tb.sv */
// Top of the parser testbench: clock, reset, byte stimulus, result back-pressure and verdict.
module tb
    import avscp_pkg::*;
;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   awaiting;
    int   quiet_cycles;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   bytes_sent;
    logic [7:0] line_bytes[$];

    avscp_cmd_if cmd_ch ();
    avscp_res_if res_ch ();

    ascii_valve_speed_command_parser u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    cmd_parser_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .res      (res_ch),
        .errors   (errors),
        .awaiting (awaiting)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CH_NL) ? 8'h00 : b;
    endfunction

    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.rx_byte <= b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(8'(s[i]));
    endtask

    task run_lines(input int quota);
        int   first;
        int   target;
        int   cmds;
        int   kind;
        int   digits;
        logic long_line;
        first = bytes_sent;
        while (bytes_sent - first < quota)
        begin
            line_bytes.delete();
            long_line = ($urandom_range(99) < 6);
            target    = long_line ? $urandom_range(LINE_MAX - 3, LINE_MAX + 8)
                                  : $urandom_range(1, 4);
            cmds = 0;
            while (long_line ? (line_bytes.size() < target) : (cmds < target))
            begin
                kind = $urandom_range(99);
                if (kind < 12)
                    line_bytes.push_back(CH_S);
                else if (kind < 42)
                begin
                    line_bytes.push_back(CH_R);
                    line_bytes.push_back(CH_ZERO + 8'(SPEED_LEAD));
                    digits = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
                    for (int i = 0; i < digits; i++)
                    begin
                        line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
                        if ($urandom_range(99) < 5)
                            line_bytes.push_back(noise_byte());
                    end
                    if ($urandom_range(99) < 10)
                    begin
                        line_bytes.push_back(noise_byte());
                        line_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
                    end
                    line_bytes.push_back(CH_PIPE);
                end
                else if (kind < 72)
                begin
                    line_bytes.push_back(CH_V);
                    line_bytes.push_back(CH_ZERO + 8'($urandom_range(VALVE_COUNT - 1)));
                    line_bytes.push_back($urandom_range(1) ? CH_Y : CH_N);
                end
                else if (kind < 80)
                begin
                    line_bytes.push_back(CH_V);
                    line_bytes.push_back($urandom_range(1) ? CH_ZERO + 8'(VALVE_COUNT)
                                                           : noise_byte());
                    line_bytes.push_back($urandom_range(1) ? CH_Y : noise_byte());
                end
                else if (kind < 86)
                begin
                    line_bytes.push_back(CH_R);
                    line_bytes.push_back(noise_byte());
                end
                else if (kind < 90)
                begin
                    line_bytes.push_back(CH_V);
                    line_bytes.push_back(CH_ZERO + 8'($urandom_range(VALVE_COUNT - 1)));
                    line_bytes.push_back(noise_byte());
                end
                else
                    line_bytes.push_back(noise_byte());
                cmds++;
            end
            if (long_line)
            begin
                while (line_bytes.size() > target)
                    void'(line_bytes.pop_back());
            end
            else if (line_bytes.size() > 1 && $urandom_range(99) < 8)
            begin
                target = $urandom_range(line_bytes.size() - 1);
                while (line_bytes.size() > target)
                    void'(line_bytes.pop_back());
            end
            line_bytes.push_back(CH_NL);
            foreach (line_bytes[i])
                send_byte(line_bytes[i]);
        end
    endtask

    initial
    begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.rx_byte = 8'h00;
        rst_n          = 1'b0;
        bytes_sent     = 0;
        send_gap_pct   = 12;
        recv_gap_pct   = 64;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                send_byte(8'h00);
                send_byte(8'hFF);
                send_text("V0YV8Y\n");
                send_text("R899999|\n");
                send_text("R8|V9YRXV3QS\n");
                run_lines(270);
                send_gap_pct = 64;
                recv_gap_pct = 12;
                run_lines(270);
                send_gap_pct = 0;
                recv_gap_pct = 0;
                run_lines(270);
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
                while (awaiting != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            wait (quiet_cycles >= STALL_LIMIT);
        join_any
        disable fork;
        if (quiet_cycles < STALL_LIMIT && errors == 0 && awaiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
